[rtl/core/idr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package idr_pkg;

  localparam int OFFSET_BITS = 24;
  localparam int MAX_PAYLOAD = 2047;

  localparam int SEQ_W  = 16;
  localparam int SIZE_W = 11;
  localparam int CNT_W  = 5;
  localparam int STAT_W = 8;

  // Configuration register indexes
  localparam logic REG_HANDSHAKE_RETRY = 1'b0;
  localparam logic REG_DOWNLOAD_RETRY  = 1'b1;
  localparam int   CFG_DATA_W          = CNT_W;

  localparam logic [CNT_W-1:0] HANDSHAKE_RETRY_RESET = CNT_W'(3);
  localparam logic [CNT_W-1:0] DOWNLOAD_RETRY_RESET  = CNT_W'(20);

  // Event kinds
  localparam logic [1:0] FUNC_START   = 2'd0;
  localparam logic [1:0] FUNC_PACKET  = 2'd1;
  localparam logic [1:0] FUNC_TIMEOUT = 2'd2;

  // Packet commands
  localparam logic [2:0] CMD_PING    = 3'd0;
  localparam logic [2:0] CMD_UPGRADE = 3'd1;
  localparam logic [2:0] CMD_START   = 3'd2;
  localparam logic [2:0] CMD_DATA    = 3'd3;
  localparam logic [2:0] CMD_FINISH  = 3'd4;

  // Packet status
  localparam logic [1:0] ST_NONE = 2'd0;
  localparam logic [1:0] ST_ACK  = 2'd1;
  localparam logic [1:0] ST_NAK  = 2'd2;

  localparam logic [STAT_W-1:0] RX_SUCCESS = STAT_W'(1);

  // Download outcome
  localparam logic [1:0] OC_IDLE = 2'd0;
  localparam logic [1:0] OC_BUSY = 2'd1;
  localparam logic [1:0] OC_OK   = 2'd2;
  localparam logic [1:0] OC_FAIL = 2'd3;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_PING    = 3'd1,
    PH_UPGRADE = 3'd2,
    PH_DATA    = 3'd3,
    PH_FINISH  = 3'd4
  } phase_t;

  typedef struct packed {
    logic [1:0]        func;
    logic [2:0]        rx_command;
    logic [STAT_W-1:0] rx_status;
    logic [SEQ_W-1:0]  rx_seq;
    logic              rx_end_of_image;
    logic [SIZE_W-1:0] rx_payload_size;
  } event_t;

  typedef struct packed {
    logic                   send_packet;
    logic [2:0]             tx_command;
    logic [1:0]             tx_status;
    logic [SEQ_W-1:0]       tx_seq;
    logic                   write_payload;
    logic [OFFSET_BITS-1:0] write_offset;
    logic [SIZE_W-1:0]      write_length;
    logic [1:0]             outcome;
    logic [OFFSET_BITS-1:0] total_length;
  } result_t;

  typedef struct packed {
    phase_t                 phase;
    logic [SEQ_W-1:0]       expected_seq;
    logic [CNT_W-1:0]       timeout_count;
    logic [OFFSET_BITS-1:0] next_offset;
    logic [OFFSET_BITS-1:0] accepted_total;
    logic [2:0]             last_tx_command;
    logic [1:0]             last_tx_status;
    logic [SEQ_W-1:0]       last_tx_seq;
  } dl_state_t;

  typedef struct packed {
    logic [CNT_W-1:0] handshake_retry_limit;
    logic [CNT_W-1:0] download_retry_limit;
  } limits_t;

endpackage

`default_nettype wire

[rtl/core/idr_evt_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface idr_evt_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   func;
  logic [2:0]                   rx_command;
  logic [idr_pkg::STAT_W-1:0]   rx_status;
  logic [idr_pkg::SEQ_W-1:0]    rx_seq;
  logic                         rx_end_of_image;
  logic [idr_pkg::SIZE_W-1:0]   rx_payload_size;

  modport source (
    output valid, func, rx_command, rx_status, rx_seq, rx_end_of_image, rx_payload_size,
    input  ready
  );

  modport sink (
    input  valid, func, rx_command, rx_status, rx_seq, rx_end_of_image, rx_payload_size,
    output ready
  );
endinterface

`default_nettype wire

[rtl/core/idr_res_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface idr_res_if;
  logic                              valid;
  logic                              ready;
  logic                              send_packet;
  logic [2:0]                        tx_command;
  logic [1:0]                        tx_status;
  logic [idr_pkg::SEQ_W-1:0]         tx_seq;
  logic                              write_payload;
  logic [idr_pkg::OFFSET_BITS-1:0]   write_offset;
  logic [idr_pkg::SIZE_W-1:0]        write_length;
  logic [1:0]                        outcome;
  logic [idr_pkg::OFFSET_BITS-1:0]   total_length;

  modport source (
    output valid, send_packet, tx_command, tx_status, tx_seq, write_payload,
           write_offset, write_length, outcome, total_length,
    input  ready
  );

  modport sink (
    input  valid, send_packet, tx_command, tx_status, tx_seq, write_payload,
           write_offset, write_length, outcome, total_length,
    output ready
  );
endinterface

`default_nettype wire

[rtl/core/image_download_receiver_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Image download receiver, device side of the download handshake.
// evt carries one event word per handshake: start, packet received (with the
// decoded header fields) or reply timeout. res returns exactly one result word
// per event: the packet to send, the payload write to perform, the download
// outcome and the running image total.
// Configuration: cfg_write with cfg_index 0 sets the handshake retry limit,
// index 1 the download retry limit; write only while no event is in flight.
// Path: an accepted event word passes from the event register through the step
// logic into the result register.
// Throughput is one event per cycle while res is not stalled; the step logic
// is combinational and the state updates per event, so events follow back to back.
// When res is stalled the result register holds and the event register still
// takes one more word; evt.ready drops only when both are full.
// Reset clears both registers, returns the download to idle with a zero total
// and restores the retry limits to 3 and 20.
module image_download_receiver_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  idr_evt_if.sink                            evt,
  idr_res_if.source                          res,
  input  wire logic                          cfg_write,
  input  wire logic                          cfg_index,
  input  wire logic [idr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import idr_pkg::*;

  logic      evt_valid;
  event_t    evt_word;
  dl_state_t st;
  dl_state_t st_next;
  limits_t   limits;
  logic      res_valid;
  result_t   res_word;
  result_t   res_calc;
  logic      res_free;
  logic      advance;

  assign res_free  = !res_valid || res.ready;
  assign advance   = evt_valid && res_free;
  assign evt.ready = !evt_valid || res_free;

  // Capture the event word
  always_ff @(posedge clk) begin
    if (rst) begin
      evt_valid <= 1'b0;
    end else if (evt.ready) begin
      evt_valid <= evt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (evt.ready && evt.valid) begin
      evt_word.func            <= evt.func;
      evt_word.rx_command      <= evt.rx_command;
      evt_word.rx_status       <= evt.rx_status;
      evt_word.rx_seq          <= evt.rx_seq;
      evt_word.rx_end_of_image <= evt.rx_end_of_image;
      evt_word.rx_payload_size <= evt.rx_payload_size;
    end
  end

  // Retry limit registers
  always_ff @(posedge clk) begin
    if (rst) begin
      limits.handshake_retry_limit <= HANDSHAKE_RETRY_RESET;
      limits.download_retry_limit  <= DOWNLOAD_RETRY_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_HANDSHAKE_RETRY: limits.handshake_retry_limit <= cfg_data;
        REG_DOWNLOAD_RETRY:  limits.download_retry_limit  <= cfg_data;
        default: ;
      endcase
    end
  end

  idr_step u_step (
    .evt     (evt_word),
    .st      (st),
    .limits  (limits),
    .st_next (st_next),
    .res     (res_calc)
  );

  // Advance the download state with each event
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase           <= PH_IDLE;
      st.expected_seq    <= '0;
      st.timeout_count   <= '0;
      st.next_offset     <= '0;
      st.accepted_total  <= '0;
      st.last_tx_command <= CMD_PING;
      st.last_tx_status  <= ST_NONE;
      st.last_tx_seq     <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // Hold the result word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_free) begin
      res_valid <= evt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_word <= res_calc;
    end
  end

  assign res.valid         = res_valid;
  assign res.send_packet   = res_word.send_packet;
  assign res.tx_command    = res_word.tx_command;
  assign res.tx_status     = res_word.tx_status;
  assign res.tx_seq        = res_word.tx_seq;
  assign res.write_payload = res_word.write_payload;
  assign res.write_offset  = res_word.write_offset;
  assign res.write_length  = res_word.write_length;
  assign res.outcome       = res_word.outcome;
  assign res.total_length  = res_word.total_length;

endmodule

`default_nettype wire

[rtl/core/idr_step.sv]
`timescale 1ns / 1ps
`default_nettype none

// Next download state and result word for one event
module idr_step (
  input  wire idr_pkg::event_t    evt,
  input  wire idr_pkg::dl_state_t st,
  input  wire idr_pkg::limits_t   limits,
  output idr_pkg::dl_state_t st_next,
  output idr_pkg::result_t  res
);
  import idr_pkg::*;

  logic                   start_ev;
  logic                   pkt_ev;
  logic                   tmo_ev;
  logic                   ping_ok;
  logic                   upg_ok;
  logic                   data_good;
  logic [OFFSET_BITS:0]   sum;
  logic                   overflow;
  logic [CNT_W-1:0]       limit_sel;
  logic [CNT_W-1:0]       limit_eff;
  logic [CNT_W:0]         count_inc;
  logic                   retry_fail;
  phase_t                 phase_next;

  // Decode the event against the current phase
  assign start_ev  = (st.phase == PH_IDLE) && (evt.func == FUNC_START);
  assign pkt_ev    = (st.phase != PH_IDLE) && (evt.func == FUNC_PACKET);
  assign tmo_ev    = (st.phase != PH_IDLE) && (evt.func == FUNC_TIMEOUT);
  assign ping_ok   = (evt.rx_command == CMD_PING) && (evt.rx_status == RX_SUCCESS);
  assign upg_ok    = (evt.rx_command == CMD_UPGRADE) && (evt.rx_status == RX_SUCCESS);
  assign data_good = (evt.rx_command == CMD_DATA) && (evt.rx_seq == st.expected_seq) &&
                     ({{(32-SIZE_W){1'b0}}, evt.rx_payload_size} <= 32'(MAX_PAYLOAD));

  // Running total with carry out as the overflow flag
  assign sum      = {1'b0, st.accepted_total} +
                    {{(OFFSET_BITS+1-SIZE_W){1'b0}}, evt.rx_payload_size};
  assign overflow = sum[OFFSET_BITS];

  // Retry limit; zero acts as one
  assign limit_sel  = (st.phase == PH_DATA) ? limits.download_retry_limit
                                            : limits.handshake_retry_limit;
  assign limit_eff  = (limit_sel == '0) ? CNT_W'(1) : limit_sel;
  assign count_inc  = {1'b0, st.timeout_count} + (CNT_W+1)'(1);
  assign retry_fail = count_inc >= {1'b0, limit_eff};

  // Next phase
  always_comb begin
    phase_next = st.phase;
    case (st.phase)
      PH_IDLE: begin
        if (start_ev) phase_next = PH_PING;
      end
      PH_PING: begin
        if (pkt_ev) phase_next = ping_ok ? PH_UPGRADE : PH_IDLE;
        else if (tmo_ev && retry_fail) phase_next = PH_IDLE;
      end
      PH_UPGRADE: begin
        if (pkt_ev) phase_next = upg_ok ? PH_DATA : PH_IDLE;
        else if (tmo_ev && retry_fail) phase_next = PH_IDLE;
      end
      PH_DATA: begin
        if (pkt_ev && data_good) begin
          if (overflow) phase_next = PH_IDLE;
          else if (evt.rx_end_of_image) phase_next = PH_FINISH;
        end else if (tmo_ev && retry_fail) begin
          phase_next = PH_IDLE;
        end
      end
      PH_FINISH: begin
        if (pkt_ev || tmo_ev) phase_next = PH_IDLE;
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  // Result word and the rest of the state
  always_comb begin
    st_next       = st;
    st_next.phase = phase_next;
    res           = '0;
    res.outcome   = (st.phase == PH_IDLE) ? OC_IDLE : OC_BUSY;

    if (start_ev) begin
      st_next.accepted_total  = '0;
      st_next.next_offset     = '0;
      st_next.expected_seq    = '0;
      st_next.timeout_count   = '0;
      st_next.last_tx_command = CMD_PING;
      st_next.last_tx_status  = ST_NONE;
      st_next.last_tx_seq     = '0;
      res.send_packet         = 1'b1;
      res.tx_command          = CMD_PING;
      res.outcome             = OC_BUSY;
    end else if (tmo_ev) begin
      if (st.phase == PH_FINISH || retry_fail) begin
        st_next.timeout_count = '0;
        res.outcome           = OC_FAIL;
      end else begin
        // Resend the last packet
        st_next.timeout_count = count_inc[CNT_W-1:0];
        res.send_packet       = 1'b1;
        res.tx_command        = st.last_tx_command;
        res.tx_status         = st.last_tx_status;
        res.tx_seq            = st.last_tx_seq;
      end
    end else if (pkt_ev) begin
      case (st.phase)
        PH_PING, PH_UPGRADE: begin
          st_next.timeout_count = '0;
          if ((st.phase == PH_PING) ? ping_ok : upg_ok) begin
            st_next.last_tx_command = (st.phase == PH_PING) ? CMD_UPGRADE : CMD_START;
            st_next.last_tx_status  = ST_NONE;
            st_next.last_tx_seq     = '0;
            res.send_packet         = 1'b1;
            res.tx_command          = st_next.last_tx_command;
          end else begin
            res.outcome = OC_FAIL;
          end
        end
        PH_DATA: begin
          st_next.timeout_count = '0;
          if (!data_good) begin
            // Answer NAK, echo the received sequence
            st_next.last_tx_command = CMD_DATA;
            st_next.last_tx_status  = ST_NAK;
            st_next.last_tx_seq     = evt.rx_seq;
            res.send_packet         = 1'b1;
            res.tx_command          = CMD_DATA;
            res.tx_status           = ST_NAK;
            res.tx_seq              = evt.rx_seq;
          end else if (overflow) begin
            res.outcome = OC_FAIL;
          end else begin
            res.write_payload      = 1'b1;
            res.write_offset       = st.next_offset;
            res.write_length       = evt.rx_payload_size;
            st_next.accepted_total = sum[OFFSET_BITS-1:0];
            if (evt.rx_end_of_image) begin
              st_next.expected_seq = '0;
            end else begin
              st_next.expected_seq    = st.expected_seq + SEQ_W'(1);
              st_next.next_offset     = st.next_offset +
                                        {{(OFFSET_BITS-SIZE_W){1'b0}}, evt.rx_payload_size};
              st_next.last_tx_command = CMD_DATA;
              st_next.last_tx_status  = ST_ACK;
              st_next.last_tx_seq     = evt.rx_seq;
              res.send_packet         = 1'b1;
              res.tx_command          = CMD_DATA;
              res.tx_status           = ST_ACK;
              res.tx_seq              = evt.rx_seq;
            end
          end
        end
        PH_FINISH: begin
          st_next.timeout_count = '0;
          res.outcome = (evt.rx_command == CMD_FINISH) ? OC_OK : OC_FAIL;
        end
        default: res.outcome = OC_FAIL;
      endcase
    end

    res.total_length = st_next.accepted_total;
  end

endmodule

`default_nettype wire
